FILE: rtl/rae_pkg.sv
// ----------------------------------------------------------------------------
// rae_pkg: shared types and constants of the earliest-free room allocator
// Booking record, back-end state codes and fixed field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package rae_pkg;

	localparam int ROOMS_DEFAULT = 16;
	localparam int LANES         = 4;
	localparam int LANE_BITS     = 2;
	localparam int IN_TIME_W     = 32;
	localparam int TIME_W        = 48;
	localparam int COUNT_W       = 32;
	localparam int ROOM_W        = 4;
	localparam int CFG_W         = 5;
	localparam int IN_TDATA_W    = 64;
	localparam int OUT_TDATA_W   = 104;
	localparam int QUEUE_DEPTH   = 2;

	typedef struct packed {
		logic [IN_TIME_W-1:0] start_time;
		logic [IN_TIME_W-1:0] end_time;
		logic [IN_TIME_W-1:0] duration;
	} booking_t;

	typedef struct packed {
		logic valid;
		logic full;
	} queue_status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_LAST,
		ST_UPDATE
	} back_state_t;

endpackage

`default_nettype wire

FILE: rtl/rae_front.sv
// ----------------------------------------------------------------------------
// rae_front: booking intake
// Accepts booking requests, works out the duration and pushes them to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module rae_front (
	input  wire logic                         s_tvalid,
	output logic                              s_tready,
	input  wire logic [rae_pkg::IN_TDATA_W-1:0] s_tdata,
	input  wire rae_pkg::queue_status_t       q_status,
	output logic                              push,
	output rae_pkg::booking_t                 booking
);

	logic [rae_pkg::IN_TIME_W-1:0] start_t;
	logic [rae_pkg::IN_TIME_W-1:0] end_t;

	assign start_t  = s_tdata[rae_pkg::IN_TIME_W-1:0];
	assign end_t    = s_tdata[2*rae_pkg::IN_TIME_W-1:rae_pkg::IN_TIME_W];
	assign s_tready = !q_status.full;
	assign push     = s_tvalid && !q_status.full;

	always_comb begin
		booking.start_time = start_t;
		booking.end_time   = end_t;
		// an end before the start counts as zero length
		booking.duration   = (end_t >= start_t) ? (end_t - start_t) : '0;
	end

endmodule

`default_nettype wire

FILE: rtl/rae_queue.sv
// ----------------------------------------------------------------------------
// rae_queue: booking queue
// Short FIFO between intake and allocation so either side can stall.
// ----------------------------------------------------------------------------
`default_nettype none

module rae_queue (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire rae_pkg::booking_t  din,
	input  wire logic               pop,
	output rae_pkg::booking_t       dout,
	output rae_pkg::queue_status_t  status
);

	localparam int PW = (rae_pkg::QUEUE_DEPTH > 1) ? $clog2(rae_pkg::QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(rae_pkg::QUEUE_DEPTH + 1);

	rae_pkg::booking_t entry_q [rae_pkg::QUEUE_DEPTH];
	logic [PW-1:0]     wr_ptr_q;
	logic [PW-1:0]     rd_ptr_q;
	logic [CW-1:0]     count_q;

	function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
		return (p == PW'(rae_pkg::QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	assign dout         = entry_q[rd_ptr_q];
	assign status.valid = (count_q != '0);
	assign status.full  = (count_q == CW'(rae_pkg::QUEUE_DEPTH));

endmodule

`default_nettype wire

FILE: rtl/rae_back.sv
// ----------------------------------------------------------------------------
// rae_back: room allocation engine
// Scans the room store four rooms a cycle, picks a room, updates the store
// and the most-booked tracking, and holds the result in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rae_back #(
	parameter int ROOMS = rae_pkg::ROOMS_DEFAULT
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [rae_pkg::CFG_W-1:0]        cfg_wdata,
	input  wire rae_pkg::queue_status_t           q_status,
	input  wire rae_pkg::booking_t                q_data,
	output logic                                  q_pop,
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	output logic [rae_pkg::OUT_TDATA_W-1:0]       m_tdata,
	output logic                                  m_tuser
);

	localparam int LANES  = rae_pkg::LANES;
	localparam int LB     = rae_pkg::LANE_BITS;
	localparam int ROWS   = (ROOMS + LANES - 1) / LANES;
	localparam int MROWS  = (ROWS > 1) ? ROWS : 2;
	localparam int RW     = $clog2(MROWS);
	localparam int IW     = RW + LB;
	localparam int NW     = (IW + 1 > rae_pkg::CFG_W) ? IW + 1 : rae_pkg::CFG_W;
	localparam int TW     = rae_pkg::TIME_W;
	localparam int KW     = rae_pkg::COUNT_W;
	localparam int RMW    = rae_pkg::ROOM_W;

	// room store, one bank per lane, a row holds one room of each lane
	logic [TW-1:0] busy_mem  [LANES][MROWS];
	logic [KW-1:0] count_mem [LANES][MROWS];
	logic          vld_q     [LANES][MROWS];

	logic [TW-1:0] rd_busy_s1 [LANES];
	logic [KW-1:0] rd_cnt_s1  [LANES];
	logic          rd_vld_s1  [LANES];

	rae_pkg::back_state_t state_q, state_d;

	logic [rae_pkg::CFG_W-1:0]     cfg_q;
	rae_pkg::booking_t             item_q;
	logic [RW-1:0]                 row_q;
	logic [RW-1:0]                 prow_s1;
	logic                          pend_s1;
	logic                          found_q;
	logic [IW-1:0]                 pick_q;
	logic [KW-1:0]                 pick_cnt_q;
	logic                          have_min_q;
	logic [IW-1:0]                 emin_q;
	logic [TW-1:0]                 min_q;
	logic [KW-1:0]                 emin_cnt_q;
	logic [KW-1:0]                 best_cnt_q;
	logic [IW-1:0]                 best_room_q;

	logic                          m_tvalid_q;
	logic [RMW-1:0]                out_room_q;
	logic [TW-1:0]                 out_start_q;
	logic [TW-1:0]                 out_end_q;
	logic                          out_waited_q;
	logic [RMW-1:0]                out_best_q;

	logic [NW-1:0]                 n_eff;
	logic [RW-1:0]                 last_row;
	logic                          out_free;
	logic                          load;
	logic                          issue;
	logic                          wr_en;

	logic [TW-1:0]                 start_ext;
	logic [TW-1:0]                 lane_busy [LANES];
	logic [KW-1:0]                 lane_cnt  [LANES];
	logic                          lane_in   [LANES];
	logic                          row_found;
	logic [LB-1:0]                 row_fidx;
	logic                          row_have;
	logic [LB-1:0]                 row_midx;
	logic [TW-1:0]                 row_min;

	logic [IW-1:0]                 sel_room;
	logic [KW-1:0]                 sel_cnt;
	logic [KW-1:0]                 new_cnt;
	logic [TW-1:0]                 a_start;
	logic [TW-1:0]                 a_end;
	logic [TW:0]                   delayed_sum;
	logic                          best_take;

	// effective room count: zero acts as one, clamp to the store size
	always_comb begin
		n_eff = NW'(cfg_q);
		if (n_eff == '0) begin
			n_eff = NW'(1);
		end else if (n_eff > NW'(ROOMS)) begin
			n_eff = NW'(ROOMS);
		end
		last_row = RW'((n_eff - NW'(1)) >> LB);
	end

	assign out_free  = !m_tvalid_q || m_tready;
	assign start_ext = TW'(item_q.start_time);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			rae_pkg::ST_IDLE: begin
				if (q_status.valid) begin
					state_d = rae_pkg::ST_SCAN;
				end
			end
			rae_pkg::ST_SCAN: begin
				if (row_q == last_row) begin
					state_d = rae_pkg::ST_LAST;
				end
			end
			rae_pkg::ST_LAST: begin
				state_d = rae_pkg::ST_UPDATE;
			end
			rae_pkg::ST_UPDATE: begin
				if (out_free) begin
					state_d = rae_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = rae_pkg::ST_IDLE;
			end
		endcase
	end

	// control outputs
	always_comb begin
		load  = 1'b0;
		issue = 1'b0;
		wr_en = 1'b0;
		case (state_q)
			rae_pkg::ST_IDLE:   load  = q_status.valid;
			rae_pkg::ST_SCAN:   issue = 1'b1;
			rae_pkg::ST_LAST:   ;
			rae_pkg::ST_UPDATE: wr_en = out_free;
			default:            ;
		endcase
	end

	assign q_pop = load;

	// per-row search: first free room and earliest-free room
	always_comb begin
		row_found = 1'b0;
		row_fidx  = '0;
		row_have  = 1'b0;
		row_midx  = '0;
		row_min   = '0;
		for (int l = 0; l < LANES; l++) begin
			lane_busy[l] = rd_vld_s1[l] ? rd_busy_s1[l] : '0;
			lane_cnt[l]  = rd_vld_s1[l] ? rd_cnt_s1[l] : '0;
			lane_in[l]   = NW'({prow_s1, LB'(l)}) < n_eff;
		end
		for (int l = LANES - 1; l >= 0; l--) begin
			if (lane_in[l] && (lane_busy[l] <= start_ext)) begin
				row_found = 1'b1;
				row_fidx  = LB'(l);
			end
		end
		for (int l = 0; l < LANES; l++) begin
			if (lane_in[l] && (!row_have || (lane_busy[l] < row_min))) begin
				row_have = 1'b1;
				row_midx = LB'(l);
				row_min  = lane_busy[l];
			end
		end
	end

	// allocation result
	always_comb begin
		delayed_sum = {1'b0, min_q} + (TW + 1)'(item_q.duration);
		if (found_q) begin
			sel_room = pick_q;
			sel_cnt  = pick_cnt_q;
			a_start  = start_ext;
			a_end    = TW'(item_q.end_time);
		end else begin
			sel_room = emin_q;
			sel_cnt  = emin_cnt_q;
			a_start  = min_q;
			a_end    = delayed_sum[TW] ? {TW{1'b1}} : delayed_sum[TW-1:0];
		end
		new_cnt   = (sel_cnt == {KW{1'b1}}) ? sel_cnt : sel_cnt + KW'(1);
		best_take = (new_cnt > best_cnt_q) ||
		            ((new_cnt == best_cnt_q) && (sel_room < best_room_q));
	end

	// store banks, read data registered
	always_ff @(posedge clk) begin
		for (int l = 0; l < LANES; l++) begin
			if (wr_en && (sel_room[LB-1:0] == LB'(l))) begin
				busy_mem[l][sel_room[IW-1:LB]]  <= a_end;
				count_mem[l][sel_room[IW-1:LB]] <= new_cnt;
			end
			rd_busy_s1[l] <= busy_mem[l][row_q];
			rd_cnt_s1[l]  <= count_mem[l][row_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int l = 0; l < LANES; l++) begin
				for (int r = 0; r < MROWS; r++) begin
					vld_q[l][r] <= 1'b0;
				end
				rd_vld_s1[l] <= 1'b0;
			end
		end else begin
			for (int l = 0; l < LANES; l++) begin
				if (wr_en && (sel_room[LB-1:0] == LB'(l))) begin
					vld_q[l][sel_room[IW-1:LB]] <= 1'b1;
				end
				rd_vld_s1[l] <= vld_q[l][row_q];
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (load) begin
			item_q <= q_data;
		end
		if (pend_s1) begin
			if (!found_q && row_found) begin
				pick_q     <= {prow_s1, row_fidx};
				pick_cnt_q <= lane_cnt[row_fidx];
			end
			if (row_have && (!have_min_q || (row_min < min_q))) begin
				emin_q     <= {prow_s1, row_midx};
				min_q      <= row_min;
				emin_cnt_q <= lane_cnt[row_midx];
			end
		end
		if (wr_en) begin
			out_room_q   <= RMW'(sel_room);
			out_start_q  <= a_start;
			out_end_q    <= a_end;
			out_waited_q <= !found_q;
			out_best_q   <= best_take ? RMW'(sel_room) : RMW'(best_room_q);
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rae_pkg::ST_IDLE;
			cfg_q       <= rae_pkg::CFG_W'(16);
			row_q       <= '0;
			prow_s1     <= '0;
			pend_s1     <= 1'b0;
			found_q     <= 1'b0;
			have_min_q  <= 1'b0;
			best_cnt_q  <= '0;
			best_room_q <= '0;
			m_tvalid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				cfg_q <= cfg_wdata;
			end
			pend_s1 <= issue;
			if (issue) begin
				prow_s1 <= row_q;
				row_q   <= row_q + RW'(1);
			end
			if (load) begin
				row_q      <= '0;
				found_q    <= 1'b0;
				have_min_q <= 1'b0;
			end else if (pend_s1) begin
				if (row_found) begin
					found_q <= 1'b1;
				end
				if (row_have) begin
					have_min_q <= 1'b1;
				end
			end
			if (wr_en && best_take) begin
				best_cnt_q  <= new_cnt;
				best_room_q <= sel_room;
			end
			if (wr_en) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = out_waited_q;
	assign m_tdata  = {out_best_q, out_end_q, out_start_q, out_room_q};

	// the last row's read data is pending on entry to the final compare
	a_last_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rae_pkg::ST_LAST) |-> pend_s1)
		else $error("last scan row not pending");

	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rae_pkg::ST_IDLE) |-> !pend_s1)
		else $error("scan read pending while idle");

	a_best_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		best_cnt_q >= $past(best_cnt_q))
		else $error("best use count went down");

	a_update_emits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rae_pkg::ST_UPDATE && out_free) |=>
		(m_tvalid_q && state_q == rae_pkg::ST_IDLE))
		else $error("update did not produce a result");

endmodule

`default_nettype wire

FILE: rtl/room_allocator_earliest_free.sv
// ----------------------------------------------------------------------------
// room_allocator_earliest_free: meeting-room allocator, earliest-free scheme
// Assigns each booking the lowest free room or the earliest-freeing one,
// and reports the most-booked room so far.
//
//   channel  dir  handshake            payload
//   s_*      in   s_tvalid/s_tready    s_tdata: start_time, end_time
//   m_*      out  m_tvalid/m_tready    m_tdata: room, actual_start, actual_end,
//                                      most_booked_room; m_tuser: waited
//   cfg      in   rooms_in_use_we      rooms_in_use_wdata
//
// In the allocation engine a booking passes the states idle, scan (over
// rows, ceil(rooms in use / 4) of them, four lanes of the room store at a
// time), last and update. Intake runs ahead into a two-entry queue.
// Reset clears all rooms at once through per-room valid bits; no sweep.
// A held result stalls only the final update; intake keeps accepting
// until the queue is full.
// ----------------------------------------------------------------------------
`default_nettype none

module room_allocator_earliest_free #(
	parameter int ROOMS = rae_pkg::ROOMS_DEFAULT
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	// [31:0] start_time, [63:32] end_time
	input  wire logic [rae_pkg::IN_TDATA_W-1:0] s_tdata,
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	// [3:0] room, [51:4] actual_start, [99:52] actual_end,
	// [103:100] most_booked_room
	output logic [rae_pkg::OUT_TDATA_W-1:0]     m_tdata,
	// [0] waited
	output logic                                m_tuser,
	input  wire logic                           rooms_in_use_we,
	input  wire logic [rae_pkg::CFG_W-1:0]      rooms_in_use_wdata
);

	rae_pkg::queue_status_t q_status;
	rae_pkg::booking_t      q_din;
	rae_pkg::booking_t      q_dout;
	logic                   q_push;
	logic                   q_pop;

	rae_front u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.q_status (q_status),
		.push     (q_push),
		.booking  (q_din)
	);

	rae_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.din    (q_din),
		.pop    (q_pop),
		.dout   (q_dout),
		.status (q_status)
	);

	rae_back #(
		.ROOMS (ROOMS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (rooms_in_use_we),
		.cfg_wdata (rooms_in_use_wdata),
		.q_status  (q_status),
		.q_data    (q_dout),
		.q_pop     (q_pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for room_allocator_earliest_free
// Drives bookings through the request stream and predicts each allocation:
// the room, the actual start and end, the waited flag and the most-booked
// room. A table of directed bookings and register writes runs first. Random
// phases follow, each under its own room count. Both stream sides idle in
// random bursts, and the result side holds off once for a long stretch.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

	localparam int TAIL_ITEMS   = 60;
	localparam int PHASE_ITEMS  = 70;
	localparam int SETTLE_CYCLES = 12;
	localparam logic [rae_pkg::TIME_W-1:0] TIME_CEIL = {rae_pkg::TIME_W{1'b1}};
	localparam logic [rae_pkg::COUNT_W-1:0] COUNT_CEIL = {rae_pkg::COUNT_W{1'b1}};

	typedef struct packed {
		logic [rae_pkg::ROOM_W-1:0] room;
		logic [rae_pkg::TIME_W-1:0] a_start;
		logic [rae_pkg::TIME_W-1:0] a_end;
		logic                       waited;
		logic [rae_pkg::ROOM_W-1:0] top_room;
	} alloc_t;

	typedef enum logic {
		STEP_BOOK,
		STEP_CFG
	} step_kind_t;

	typedef struct packed {
		step_kind_t                    kind;
		logic [rae_pkg::CFG_W-1:0]     cfg;
		logic [rae_pkg::IN_TIME_W-1:0] st;
		logic [rae_pkg::IN_TIME_W-1:0] en;
		logic                          typed;
		alloc_t                        want;
	} step_t;

	localparam step_t DIRECTED [21] = '{
		'{STEP_BOOK, 5'd0, 32'd0, 32'd0, 1'b1, '{4'd0, 48'd0, 48'd0, 1'b0, 4'd0}},
		'{STEP_BOOK, 5'd0, 32'd0, 32'hFFFF_FFFF, 1'b1,
			'{4'd0, 48'd0, 48'hFFFF_FFFF, 1'b0, 4'd0}},
		'{STEP_BOOK, 5'd0, 32'd5, 32'd10, 1'b1, '{4'd1, 48'd5, 48'd10, 1'b0, 4'd0}},
		// end before start, no wait: the given end stands
		'{STEP_BOOK, 5'd0, 32'd10, 32'd3, 1'b1, '{4'd1, 48'd10, 48'd3, 1'b0, 4'd0}},
		'{STEP_BOOK, 5'd0, 32'd20, 32'd30, 1'b1, '{4'd1, 48'd20, 48'd30, 1'b0, 4'd1}},
		// count tie goes back to the lower room
		'{STEP_BOOK, 5'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
			'{4'd0, 48'hFFFF_FFFF, 48'hFFFF_FFFF, 1'b0, 4'd0}},
		'{STEP_CFG, 5'd1, 32'd0, 32'd0, 1'b0, '0},
		'{STEP_BOOK, 5'd0, 32'd40, 32'd50, 1'b1,
			'{4'd0, 48'hFFFF_FFFF, 48'h1_0000_0009, 1'b1, 4'd0}},
		'{STEP_BOOK, 5'd0, 32'd40, 32'd30, 1'b0, '0},
		'{STEP_CFG, 5'd0, 32'd0, 32'd0, 1'b0, '0},
		'{STEP_BOOK, 5'd0, 32'd60, 32'd70, 1'b0, '0},
		'{STEP_CFG, 5'd31, 32'd0, 32'd0, 1'b0, '0},
		'{STEP_BOOK, 5'd0, 32'd100, 32'd200, 1'b0, '0},
		'{STEP_BOOK, 5'd0, 32'd100, 32'd100, 1'b0, '0},
		'{STEP_CFG, 5'd2, 32'd0, 32'd0, 1'b0, '0},
		'{STEP_BOOK, 5'd0, 32'd150, 32'd160, 1'b0, '0},
		'{STEP_BOOK, 5'd0, 32'd5, 32'd1, 1'b0, '0},
		'{STEP_CFG, 5'd17, 32'd0, 32'd0, 1'b0, '0},
		'{STEP_BOOK, 5'd0, 32'd0, 32'd0, 1'b0, '0},
		'{STEP_BOOK, 5'd0, 32'd210, 32'd500, 1'b0, '0},
		'{STEP_CFG, 5'd16, 32'd0, 32'd0, 1'b0, '0}
	};

	localparam logic [rae_pkg::CFG_W-1:0] PHASE_ROOMS [9] = '{
		5'd16, 5'd3, 5'd1, 5'd8, 5'd31, 5'd0, 5'd2, 5'd17, 5'd16
	};

	logic                             clk;
	logic                             arst_n;
	logic                             s_tvalid;
	logic                             s_tready;
	logic [rae_pkg::IN_TDATA_W-1:0]   s_tdata;
	logic                             m_tvalid;
	logic                             m_tready;
	logic [rae_pkg::OUT_TDATA_W-1:0]  m_tdata;
	logic                             m_tuser;
	logic                             rooms_in_use_we;
	logic [rae_pkg::CFG_W-1:0]        rooms_in_use_wdata;

	// allocator mirror
	logic [rae_pkg::TIME_W-1:0]  room_busy_until [rae_pkg::ROOMS_DEFAULT];
	logic [rae_pkg::COUNT_W-1:0] room_use_count [rae_pkg::ROOMS_DEFAULT];
	logic [rae_pkg::COUNT_W-1:0] top_count;
	logic [rae_pkg::ROOM_W-1:0]  top_room;
	logic [rae_pkg::CFG_W-1:0]   rooms_setting;

	alloc_t pending_allocs [$];
	int     fail_count;
	int     results_seen;
	bit     calm_tail;
	bit     hold_done;

	room_allocator_earliest_free u_top (
		.clk                (clk),
		.arst_n             (arst_n),
		.s_tvalid           (s_tvalid),
		.s_tready           (s_tready),
		.s_tdata            (s_tdata),
		.m_tvalid           (m_tvalid),
		.m_tready           (m_tready),
		.m_tdata            (m_tdata),
		.m_tuser            (m_tuser),
		.rooms_in_use_we    (rooms_in_use_we),
		.rooms_in_use_wdata (rooms_in_use_wdata)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic alloc_t allocate_booking(logic [rae_pkg::IN_TIME_W-1:0] st,
			logic [rae_pkg::IN_TIME_W-1:0] en);
		alloc_t                      res;
		logic [rae_pkg::TIME_W-1:0]  st_w;
		logic [rae_pkg::TIME_W-1:0]  en_w;
		logic [rae_pkg::TIME_W-1:0]  span;
		int                          n;
		int                          pick;
		int                          earliest;
		bit                          found;
		st_w = rae_pkg::TIME_W'(st);
		en_w = rae_pkg::TIME_W'(en);
		span = (en_w >= st_w) ? en_w - st_w : '0;
		n = rooms_setting;
		if (n == 0) n = 1;
		if (n > rae_pkg::ROOMS_DEFAULT) n = rae_pkg::ROOMS_DEFAULT;
		pick = 0;
		earliest = 0;
		found = 1'b0;
		for (int i = 0; i < n; i++) begin
			if (!found && room_busy_until[i] <= st_w) begin
				pick = i;
				found = 1'b1;
			end
			if (room_busy_until[i] < room_busy_until[earliest]) earliest = i;
		end
		if (found) begin
			res.waited = 1'b0;
			res.a_start = st_w;
			res.a_end = en_w;
		end else begin
			pick = earliest;
			res.waited = 1'b1;
			res.a_start = room_busy_until[pick];
			res.a_end = (res.a_start > TIME_CEIL - span) ? TIME_CEIL : res.a_start + span;
		end
		room_busy_until[pick] = res.a_end;
		if (room_use_count[pick] != COUNT_CEIL) room_use_count[pick]++;
		if (room_use_count[pick] > top_count ||
				(room_use_count[pick] == top_count &&
				rae_pkg::ROOM_W'(pick) < top_room)) begin
			top_count = room_use_count[pick];
			top_room = rae_pkg::ROOM_W'(pick);
		end
		res.room = rae_pkg::ROOM_W'(pick);
		res.top_room = top_room;
		return res;
	endfunction

	task automatic pause_requests(int cycles);
		s_tvalid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// offer one request and hold it until taken; valid stays high afterwards
	task automatic send_booking(logic [rae_pkg::IN_TIME_W-1:0] st,
			logic [rae_pkg::IN_TIME_W-1:0] en, logic typed, alloc_t want);
		alloc_t p;
		if (!calm_tail && $urandom_range(0, 4) == 0) pause_requests($urandom_range(1, 12));
		s_tvalid <= 1'b1;
		s_tdata <= {en, st};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		p = allocate_booking(st, en);
		pending_allocs.push_back(typed ? want : p);
	endtask

	task automatic write_rooms(logic [rae_pkg::CFG_W-1:0] value);
		s_tvalid <= 1'b0;
		while (pending_allocs.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		rooms_in_use_we <= 1'b1;
		rooms_in_use_wdata <= value;
		@(posedge clk);
		rooms_setting = value;
		rooms_in_use_we <= 1'b0;
	endtask

	task automatic flag_field(string what, logic [rae_pkg::TIME_W-1:0] want_v,
			logic [rae_pkg::TIME_W-1:0] got_v);
		if (want_v !== got_v) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want_v, got_v);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin : result_check
		alloc_t got;
		alloc_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.room = m_tdata[3:0];
			got.a_start = m_tdata[51:4];
			got.a_end = m_tdata[99:52];
			got.top_room = m_tdata[103:100];
			got.waited = m_tuser;
			if (pending_allocs.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
				fail_count++;
			end else begin
				want = pending_allocs.pop_front();
				flag_field("room", rae_pkg::TIME_W'(want.room), rae_pkg::TIME_W'(got.room));
				flag_field("actual_start", want.a_start, got.a_start);
				flag_field("actual_end", want.a_end, got.a_end);
				flag_field("waited", rae_pkg::TIME_W'(want.waited),
					rae_pkg::TIME_W'(got.waited));
				flag_field("most_booked_room", rae_pkg::TIME_W'(want.top_room),
					rae_pkg::TIME_W'(got.top_room));
			end
			results_seen++;
		end
	end

	// result side: random stalls, one long hold-off, steady in the tail
	initial begin : result_pacing
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (calm_tail) begin
				m_tready <= 1'b1;
				@(posedge clk);
			end else if (!hold_done && results_seen >= 150) begin
				m_tready <= 1'b0;
				for (int k = 0; k < 300; k++) @(posedge clk);
				hold_done = 1'b1;
			end else if ($urandom_range(0, 3) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
				repeat ($urandom_range(1, 40)) @(posedge clk);
			end
		end
	end

	initial begin : watchdog
		#3_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin : stimulus
		logic [rae_pkg::IN_TIME_W-1:0] st;
		logic [rae_pkg::IN_TIME_W-1:0] en;
		logic [rae_pkg::IN_TIME_W-1:0] clock_now;
		int                            mode;
		int                            sent;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		rooms_in_use_we = 1'b0;
		rooms_in_use_wdata = '0;
		fail_count = 0;
		results_seen = 0;
		calm_tail = 1'b0;
		hold_done = 1'b0;
		for (int i = 0; i < rae_pkg::ROOMS_DEFAULT; i++) begin
			room_busy_until[i] = '0;
			room_use_count[i] = '0;
		end
		top_count = '0;
		top_room = '0;
		rooms_setting = rae_pkg::CFG_W'(16);
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED[k]) begin
			if (DIRECTED[k].kind == STEP_CFG) write_rooms(DIRECTED[k].cfg);
			else send_booking(DIRECTED[k].st, DIRECTED[k].en, DIRECTED[k].typed,
					DIRECTED[k].want);
		end

		clock_now = 32'd1000;
		sent = 0;
		foreach (PHASE_ROOMS[ph]) begin
			write_rooms(PHASE_ROOMS[ph]);
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				mode = $urandom_range(0, 19);
				if (mode == 0) begin
					// stray request anywhere in time; end usually lands before start
					st = $urandom;
					en = $urandom_range(0, clock_now);
				end else if (mode == 1) begin
					st = clock_now;
					en = clock_now - $urandom_range(1, 100);
				end else if (mode == 2) begin
					st = clock_now - $urandom_range(0, 200);
					en = st + $urandom_range(0, 500);
				end else begin
					st = clock_now;
					en = st + ((mode < 12) ? $urandom_range(0, 200) : $urandom_range(0, 3000));
				end
				clock_now = clock_now + $urandom_range(0, 300);
				if (sent >= PHASE_ITEMS * $size(PHASE_ROOMS) - TAIL_ITEMS) calm_tail = 1'b1;
				send_booking(st, en, 1'b0, '0);
				sent++;
			end
		end

		s_tvalid <= 1'b0;
		while (pending_allocs.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

`default_nettype wire

FILE: room_allocator_earliest_free.f
rtl/rae_pkg.sv
rtl/rae_front.sv
rtl/rae_queue.sv
rtl/rae_back.sv
rtl/room_allocator_earliest_free.sv
tb/testbench.sv
